/* hw/rtl/dhc_pkg.sv */
`default_nettype none

package dhc_pkg;

    // Widths of the pixel and of the hue numerator (max * 240 fits in 16 bits).
    localparam int PIX_W = 8;
    localparam int NUM_W = 16;
    localparam int M_W   = 6;

    localparam logic [PIX_W-1:0] HUE_SPAN     = 8'd240;
    localparam logic [PIX_W-1:0] SECTOR_SPAN  = 8'd60;
    localparam logic [PIX_W-1:0] FULL_LEVEL   = 8'd255;
    localparam logic [4:0]       RAMP_SLOPE   = 5'd17;

    // Configuration register indexes.
    localparam logic CFG_MAX_DISPARITY = 1'b0;
    localparam logic CFG_BLANK_ZERO    = 1'b1;

    // Hue sectors.
    localparam logic [2:0] SEC_RED_GREEN  = 3'd0;
    localparam logic [2:0] SEC_GREEN_RED  = 3'd1;
    localparam logic [2:0] SEC_GREEN_BLUE = 3'd2;
    localparam logic [2:0] SEC_BLUE_GREEN = 3'd3;
    localparam logic [2:0] SEC_BLUE_RED   = 3'd4;

    // One restoring division step: compares the partial remainder with the
    // divisor shifted left by sh. The top bit of the result is the quotient bit.
    function automatic logic [NUM_W:0] div_step(
        input logic [NUM_W-1:0] rem,
        input logic [PIX_W-1:0] dvs,
        input logic [2:0]       sh
    );
        logic [NUM_W-1:0] trial;
        trial = NUM_W'(dvs) << sh;
        if (rem >= trial) begin
            div_step = {1'b1, rem - trial};
        end else begin
            div_step = {1'b0, rem};
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/disparity_hue_colormap.sv */
`default_nettype none

// Colorizes one 8-bit disparity pixel per beat into a blue, green, red pixel on a
// hue ramp: the configured maximum disparity is red, zero is blue, and values above
// the maximum are saturated to red. A maximum of zero gives black, and with
// blank_zero set a zero disparity also gives black. The block takes one pixel per
// clock while the output is not stalled. Each pixel passes through pipeline stages that
// form the hue numerator, run the hue division two quotient bits at a time, split the
// hue into sector and offset, and build the color in the output register. Valid bits
// travel with every stage, so bubbles close up while the output is stalled. Configuration
// is written through cfg_wr_en, cfg_addr and cfg_wdata and should only change while no
// pixels are in flight.
module disparity_hue_colormap (
    input  wire                       aclk,
    input  wire                       aresetn,

    input  wire                       cfg_wr_en,
    input  wire                       cfg_addr,
    input  wire [dhc_pkg::PIX_W-1:0]  cfg_wdata,

    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire [dhc_pkg::PIX_W-1:0]  s_disparity,

    output logic                      m_valid,
    input  wire                       m_ready,
    output logic [dhc_pkg::PIX_W-1:0] m_blue,
    output logic [dhc_pkg::PIX_W-1:0] m_green,
    output logic [dhc_pkg::PIX_W-1:0] m_red
);
    import dhc_pkg::*;

    localparam int DIV_STAGES = 4;
    localparam int LAST       = DIV_STAGES + 2;

    logic [PIX_W-1:0] max_disp_reg;
    logic             blank_zero_reg;

    logic             vld_reg [0:LAST];
    logic             rdy     [0:LAST];

    logic [NUM_W-1:0] rem_reg [0:DIV_STAGES-1];
    logic [PIX_W-1:0] mx_reg  [0:DIV_STAGES-1];
    logic [PIX_W-1:0] quo_reg [0:DIV_STAGES];
    logic             blk_reg [0:DIV_STAGES+1];

    logic [2:0]       sector_reg;
    logic [M_W-1:0]   m_reg;
    logic [PIX_W-1:0] blue_reg;
    logic [PIX_W-1:0] green_reg;
    logic [PIX_W-1:0] red_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_disp_reg   <= FULL_LEVEL;
            blank_zero_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAX_DISPARITY: max_disp_reg   <= cfg_wdata;
                CFG_BLANK_ZERO:    blank_zero_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its contents move on.
    always_comb begin
        rdy[LAST] = !vld_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: saturate the pixel and form (max - d) * 240.
    logic [PIX_W-1:0] d_sat;
    logic [PIX_W-1:0] diff;
    logic             black;

    always_comb begin
        d_sat = (s_disparity > max_disp_reg) ? max_disp_reg : s_disparity;
        diff  = max_disp_reg - d_sat;
        black = (max_disp_reg == '0) || (blank_zero_reg && (s_disparity == '0));
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            rem_reg[0] <= NUM_W'(diff) * NUM_W'(HUE_SPAN);
            mx_reg[0]  <= max_disp_reg;
            quo_reg[0] <= '0;
            blk_reg[0] <= black;
        end
    end

    // Stages 1 to 4: the hue quotient is below 256, so eight restoring steps,
    // two per stage, give it exactly.
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        localparam logic [2:0] SH_HI = 3'(2 * (DIV_STAGES - k) + 1);
        localparam logic [2:0] SH_LO = 3'(2 * (DIV_STAGES - k));

        logic [NUM_W:0] step_hi;
        logic [NUM_W:0] step_lo;

        always_comb begin
            step_hi = div_step(rem_reg[k-1], mx_reg[k-1], SH_HI);
            step_lo = div_step(step_hi[NUM_W-1:0], mx_reg[k-1], SH_LO);
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                quo_reg[k] <= {quo_reg[k-1][PIX_W-3:0], step_hi[NUM_W], step_lo[NUM_W]};
                blk_reg[k] <= blk_reg[k-1];
            end
        end

        if (k < DIV_STAGES) begin : g_carry
            always_ff @(posedge aclk) begin
                if (rdy[k]) begin
                    rem_reg[k] <= step_lo[NUM_W-1:0];
                    mx_reg[k]  <= mx_reg[k-1];
                end
            end
        end
    end

    // Stage 5: split the hue into a sixty-wide sector and the offset within it.
    logic [PIX_W-1:0] hue;
    logic [2:0]       sector;
    logic [PIX_W-1:0] base;

    always_comb begin
        hue = quo_reg[DIV_STAGES];
        if (hue >= 8'(4 * SECTOR_SPAN)) begin
            sector = SEC_BLUE_RED;
            base   = 8'(4 * SECTOR_SPAN);
        end else if (hue >= 8'(3 * SECTOR_SPAN)) begin
            sector = SEC_BLUE_GREEN;
            base   = 8'(3 * SECTOR_SPAN);
        end else if (hue >= 8'(2 * SECTOR_SPAN)) begin
            sector = SEC_GREEN_BLUE;
            base   = 8'(2 * SECTOR_SPAN);
        end else if (hue >= SECTOR_SPAN) begin
            sector = SEC_GREEN_RED;
            base   = SECTOR_SPAN;
        end else begin
            sector = SEC_RED_GREEN;
            base   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[DIV_STAGES+1]) begin
            sector_reg              <= sector;
            m_reg                   <= M_W'(hue - base);
            blk_reg[DIV_STAGES+1]   <= blk_reg[DIV_STAGES];
        end
    end

    // Stage 6: rising and falling ramps, then pick the components by sector.
    logic [9:0]       rise_prod;
    logic [9:0]       fall_prod;
    logic [PIX_W-1:0] rise;
    logic [PIX_W-1:0] fall;
    logic [PIX_W-1:0] b_next;
    logic [PIX_W-1:0] g_next;
    logic [PIX_W-1:0] r_next;

    always_comb begin
        rise_prod = 10'(m_reg) * 10'(RAMP_SLOPE);
        fall_prod = (10'(SECTOR_SPAN) - 10'(m_reg)) * 10'(RAMP_SLOPE);
        rise      = rise_prod[9:2];
        fall      = fall_prod[9:2];
        case (sector_reg)
            SEC_RED_GREEN: begin
                b_next = '0;         g_next = rise;       r_next = FULL_LEVEL;
            end
            SEC_GREEN_RED: begin
                b_next = '0;         g_next = FULL_LEVEL; r_next = fall;
            end
            SEC_GREEN_BLUE: begin
                b_next = rise;       g_next = FULL_LEVEL; r_next = '0;
            end
            SEC_BLUE_GREEN: begin
                b_next = FULL_LEVEL; g_next = fall;       r_next = '0;
            end
            SEC_BLUE_RED: begin
                b_next = FULL_LEVEL; g_next = '0;         r_next = rise;
            end
            default: begin
                b_next = fall;       g_next = '0;         r_next = FULL_LEVEL;
            end
        endcase
        if (blk_reg[DIV_STAGES+1]) begin
            b_next = '0;
            g_next = '0;
            r_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[LAST]) begin
            blue_reg  <= b_next;
            green_reg <= g_next;
            red_reg   <= r_next;
        end
    end

    assign m_valid = vld_reg[LAST];
    assign m_blue  = blue_reg;
    assign m_green = green_reg;
    assign m_red   = red_reg;

endmodule

`default_nettype wire

/* sim/disparity_hue_colormap_checker.sv */
`timescale 1ns / 1ps

module disparity_hue_colormap_checker (
    input  wire                       aclk,
    input  wire                       aresetn,

    input  wire                       cfg_wr_en,
    input  wire                       cfg_addr,
    input  wire [dhc_pkg::PIX_W-1:0]  cfg_wdata,

    input  wire                       s_valid,
    input  wire                       s_ready,
    input  wire [dhc_pkg::PIX_W-1:0]  s_disparity,

    input  wire                       m_valid,
    input  wire                       m_ready,
    input  wire [dhc_pkg::PIX_W-1:0]  m_blue,
    input  wire [dhc_pkg::PIX_W-1:0]  m_green,
    input  wire [dhc_pkg::PIX_W-1:0]  m_red,

    output int                        pending_count,
    output int                        fail_count
);

    typedef struct packed {
        logic [dhc_pkg::PIX_W-1:0] blue;
        logic [dhc_pkg::PIX_W-1:0] green;
        logic [dhc_pkg::PIX_W-1:0] red;
    } pixel_bgr_t;

    // Far more room than the pipeline can ever hold in flight.
    localparam int EXP_DEPTH = 64;

    pixel_bgr_t                expected_pixels [0:EXP_DEPTH-1];
    pixel_bgr_t                want;
    int                        exp_wr     = 0;
    int                        exp_rd     = 0;
    int                        exp_held   = 0;
    logic [dhc_pkg::PIX_W-1:0] max_disp   = 8'd255;
    logic                      blank_zero = 1'b1;
    int                        failures   = 0;

    function automatic pixel_bgr_t colorize_pixel(input logic [dhc_pkg::PIX_W-1:0] disp);
        pixel_bgr_t  px;
        int unsigned mx_u;
        int unsigned d_u;
        int unsigned hue;
        int unsigned offs;
        int unsigned rise;
        int unsigned fall;
        logic [2:0]  sector;
        px   = '0;
        mx_u = max_disp;
        d_u  = disp;
        if (mx_u != 0 && !(blank_zero && d_u == 0)) begin
            // Anything nearer than the maximum is clamped to it and shows red.
            if (d_u > mx_u) begin
                d_u = mx_u;
            end
            hue    = ((mx_u - d_u) * dhc_pkg::HUE_SPAN) / mx_u;
            sector = 3'(hue / dhc_pkg::SECTOR_SPAN);
            offs   = hue % dhc_pkg::SECTOR_SPAN;
            rise   = (offs * dhc_pkg::RAMP_SLOPE) / 4;
            fall   = ((dhc_pkg::SECTOR_SPAN - offs) * dhc_pkg::RAMP_SLOPE) / 4;
            case (sector)
                dhc_pkg::SEC_RED_GREEN: begin
                    px.green = 8'(rise);
                    px.red   = dhc_pkg::FULL_LEVEL;
                end
                dhc_pkg::SEC_GREEN_RED: begin
                    px.green = dhc_pkg::FULL_LEVEL;
                    px.red   = 8'(fall);
                end
                dhc_pkg::SEC_GREEN_BLUE: begin
                    px.blue  = 8'(rise);
                    px.green = dhc_pkg::FULL_LEVEL;
                end
                dhc_pkg::SEC_BLUE_GREEN: begin
                    px.blue  = dhc_pkg::FULL_LEVEL;
                    px.green = 8'(fall);
                end
                dhc_pkg::SEC_BLUE_RED: begin
                    px.blue  = dhc_pkg::FULL_LEVEL;
                    px.red   = 8'(rise);
                end
                default: begin
                    px.blue  = 8'(fall);
                    px.red   = dhc_pkg::FULL_LEVEL;
                end
            endcase
        end
        return px;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_disp   = 8'd255;
            blank_zero = 1'b1;
            exp_wr     = 0;
            exp_rd     = 0;
            exp_held   = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pixels[exp_wr] = colorize_pixel(s_disparity);
                exp_wr   = (exp_wr + 1) % EXP_DEPTH;
                exp_held = exp_held + 1;
            end
            if (m_valid && m_ready) begin
                if (exp_held == 0) begin
                    note_failure($sformatf("unexpected pixel b=%0d g=%0d r=%0d",
                                           m_blue, m_green, m_red));
                end else begin
                    want     = expected_pixels[exp_rd];
                    exp_rd   = (exp_rd + 1) % EXP_DEPTH;
                    exp_held = exp_held - 1;
                    if (want.blue !== m_blue || want.green !== m_green || want.red !== m_red) begin
                        note_failure($sformatf(
                            "pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                            want.blue, want.green, want.red, m_blue, m_green, m_red));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    dhc_pkg::CFG_MAX_DISPARITY: max_disp   = cfg_wdata;
                    dhc_pkg::CFG_BLANK_ZERO:    blank_zero = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending_count <= exp_held;
        fail_count    <= failures;
    end

endmodule

/* sim/disparity_hue_colormap_tb.sv */
`timescale 1ns / 1ps

module disparity_hue_colormap_tb;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic                      cfg_addr    = dhc_pkg::CFG_MAX_DISPARITY;
    logic [dhc_pkg::PIX_W-1:0] cfg_wdata   = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [dhc_pkg::PIX_W-1:0] s_disparity = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic [dhc_pkg::PIX_W-1:0] m_blue;
    logic [dhc_pkg::PIX_W-1:0] m_green;
    logic [dhc_pkg::PIX_W-1:0] m_red;

    int                        pending_count;
    int                        fail_count;
    idle_mode_e                idle_mode   = IDLE_NONE;
    logic [dhc_pkg::PIX_W-1:0] cur_max     = 8'd255;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    disparity_hue_colormap u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_disparity (s_disparity),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_blue      (m_blue),
        .m_green     (m_green),
        .m_red       (m_red)
    );

    disparity_hue_colormap_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_disparity   (s_disparity),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_blue        (m_blue),
        .m_green       (m_green),
        .m_red         (m_red),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= ($urandom_range(0, 99) >= 50);
            IDLE_BOTH:     m_ready <= ($urandom_range(0, 99) >= 36);
            default:       m_ready <= 1'b1;
        endcase
    end

    task automatic send_pixel(input logic [dhc_pkg::PIX_W-1:0] disp);
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 50 : (idle_mode == IDLE_BOTH) ? 36 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_disparity <= disp;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // The pending count is registered in the checker, so step the clock before polling it.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_config(input logic [dhc_pkg::PIX_W-1:0] mx, input logic blank);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= dhc_pkg::CFG_MAX_DISPARITY;
        cfg_wdata <= mx;
        @(posedge aclk);
        cfg_addr  <= dhc_pkg::CFG_BLANK_ZERO;
        cfg_wdata <= {7'd0, blank};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_max = mx;
    endtask

    initial begin
        int unsigned               sel;
        logic [dhc_pkg::PIX_W-1:0] disp;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero is blanked, the rest spans the sectors up to blue-green.
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd20);
        send_pixel(8'd64);
        send_pixel(8'd128);
        send_pixel(8'd170);
        settle();

        // Zero shows pure blue when not blanked; values above the maximum clamp to red.
        set_config(8'd100, 1'b0);
        send_pixel(8'd0);
        send_pixel(8'd100);
        send_pixel(8'd101);
        send_pixel(8'd255);
        send_pixel(8'd50);
        send_pixel(8'd25);
        settle();

        // A zero maximum turns everything black.
        set_config(8'd0, 1'b1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        settle();
        set_config(8'd0, 1'b0);
        send_pixel(8'd0);
        send_pixel(8'd200);
        settle();

        set_config(8'd1, 1'b0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd2);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(8'd255, 1'b0);
                1: set_config(8'd1, 1'b1);
                2: set_config(8'd0, 1'b0);
                3: set_config(8'($urandom_range(2, 254)), 1'($urandom_range(0, 1)));
                4: set_config(8'd255, 1'b1);
                5: set_config(8'($urandom_range(1, 255)), 1'b0);
                6: set_config(8'($urandom_range(1, 255)), 1'b1);
                default: set_config(8'd60, 1'b0);
            endcase
            idle_mode <= idle_mode_e'(phase % 4);
            repeat (200) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       disp = 8'd0;
                    1:       disp = 8'd255;
                    2:       disp = cur_max;
                    3:       disp = cur_max + 8'($urandom_range(0, 2)) - 8'd1;
                    default: disp = 8'($urandom_range(0, 255));
                endcase
                send_pixel(disp);
            end
            settle();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("disparity_hue_colormap verification clean");
        end else begin
            $display("disparity_hue_colormap verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("disparity_hue_colormap verification failed");
        $finish;
    end

endmodule
